// ===== design/mss_pkg.sv =====
`default_nettype none

package mss_pkg;

   // Table and field geometry
   localparam int MSS_MAX_STEPS = 16;
   localparam int IDX_MAX_W     = 6;
   localparam int COUNT_W       = 32;
   localparam int NOTE_W        = 7;
   localparam int VEL_W         = 7;
   localparam int CUTOFF_W      = 15;
   localparam int STEP_W        = 4;
   localparam int SPS_W         = 16;
   localparam int PLEN_W        = 5;
   localparam int ACTION_W      = 3;
   localparam int KIND_W        = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int REQ_TDATA_W   = 72;
   localparam int RSP_TDATA_W   = 40;

   // Reset and fixed values
   localparam logic [PLEN_W-1:0]   PLEN_RESET       = 5'd16;
   localparam logic [SPS_W-1:0]    SPS_RESET        = 16'd5512;
   localparam logic [VEL_W-1:0]    DEF_VELOCITY     = 7'd88;
   localparam logic [CUTOFF_W-1:0] DEF_CUTOFF       = 15'd1000;
   localparam logic [VEL_W-1:0]    ACCENT_VELOCITY  = 7'd127;
   localparam logic [NOTE_W-1:0]   BASE_NOTE        = 7'd36;
   localparam logic [IDX_MAX_W-1:0] NOTES_PER_OCTAVE = 6'd12;
   localparam int OCTAVE_FOLDS = (2**IDX_MAX_W - 1) / 12;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_STEP = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 3'd0,
      ACT_HOST  = 3'd1,
      ACT_START = 3'd2,
      ACT_STOP  = 3'd3,
      ACT_WRITE = 3'd4
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NOTE_OFF = 2'd0,
      KIND_NOTE_ON  = 2'd1,
      KIND_SLIDE    = 2'd2,
      KIND_CUTOFF   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
      logic [CUTOFF_W-1:0] cutoff;
      logic                active;
      logic                accent;
      logic                slide;
      logic                chained;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller to datapath
   typedef struct packed {
      logic     capture;
      logic     rd_cur;
      logic     rd_nxt;
      logic     latch_cur;
      logic     latch_nxt;
      logic     div_host;
      logic     div_adv;
      logic     host_on;
      logic     host_off;
      logic     set_cur;
      logic     pos_step;
      logic     start;
      logic     stop;
      logic     write;
      logic     emit;
      kind_type emit_kind;
      logic     emit_stop;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type action;
      logic       tick_go;
      logic       pos_zero;
      logic       step_end;
      logic       host_take;
      logic       div_busy;
      logic       next_differs;
      logic       sounding;
      logic       off_en;
      logic       slide_en;
      logic       on_en;
      logic       out_free;
   } status_type;

   // Entry content after reset: note folds into one octave above the base
   function automatic entry_type default_entry(input logic [IDX_MAX_W-1:0] idx);
      entry_type            e;
      logic [IDX_MAX_W-1:0] r;
      r = idx;
      for (int k = 0; k < OCTAVE_FOLDS; k++) begin
         if (r >= NOTES_PER_OCTAVE) r = r - NOTES_PER_OCTAVE;
      end
      e.note     = BASE_NOTE + NOTE_W'(r);
      e.velocity = DEF_VELOCITY;
      e.cutoff   = DEF_CUTOFF;
      e.active   = 1'b1;
      e.accent   = 1'b0;
      e.slide    = 1'b0;
      e.chained  = 1'b0;
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== design/midi_step_sequencer.sv =====
// Step sequencer with accent, slide and tie over a table of MAX_STEPS steps.
// req_ channel takes one word per action: sample tick, host position, start,
// stop or step write (action in req_tuser). rsp_ channel delivers note-off,
// slide controller, note-on and cutoff words; rsp_tlast marks the final word
// caused by one request. csr_ port sets pattern length and samples per step.
// One request is worked at a time; req_tready is high only while idle.
// Start, write, an ignored tick or a silent stop go from decode straight back
// to idle; a tick inside a step passes through the advance state, and a stop
// with a sounding note through the stop event state. A tick that enters a
// step reads the table (read current, latch current, latch next) and then
// visits the four event slots, emitting up to four words. Ending a step and
// each host position that the host takes pass through a 1-bit-per-cycle
// remainder unit over the 32-bit count.
// Results sit in an output register: while rsp_tready is low the word holds
// and the controller waits before the next word. Reset stops playback,
// restores the default pattern and registers, and emits nothing.
`default_nettype none

module midi_step_sequencer
   import mss_pkg::*;
#(
   parameter int MAX_STEPS = MSS_MAX_STEPS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // host_running[0], host_step_count[32:1], step_index[36:33],
   // note_number[43:37], step_velocity[50:44], cutoff_value[65:51],
   // step_active[66], step_accent[67], step_slide[68], step_chained[69]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // action[2:0]
   input  wire logic [ACTION_W-1:0]    req_tuser,
   // Result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // event_note[6:0], event_velocity[13:7], event_step[17:14],
   // event_cutoff[32:18]
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // event_kind[1:0]
   output logic      [KIND_W-1:0]      rsp_tuser,
   // last_event
   output logic                        rsp_tlast,
   // Configuration write port
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type             cmd;
   status_type          stat;
   entry_type           in_entry;
   kind_type            rsp_kind;
   logic [NOTE_W-1:0]   rsp_note;
   logic [VEL_W-1:0]    rsp_velocity;
   logic [STEP_W-1:0]   rsp_step;
   logic [CUTOFF_W-1:0] rsp_cutoff;

   // Unpack the step contents
   assign in_entry.note     = req_tdata[43:37];
   assign in_entry.velocity = req_tdata[50:44];
   assign in_entry.cutoff   = req_tdata[65:51];
   assign in_entry.active   = req_tdata[66];
   assign in_entry.accent   = req_tdata[67];
   assign in_entry.slide    = req_tdata[68];
   assign in_entry.chained  = req_tdata[69];

   mss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   mss_datapath #(
      .MAX_STEPS(MAX_STEPS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .in_action         (req_tuser),
      .in_host_running   (req_tdata[0]),
      .in_host_step_count(req_tdata[32:1]),
      .in_step_index     (req_tdata[36:33]),
      .in_entry          (in_entry),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_kind          (rsp_kind),
      .rsp_note          (rsp_note),
      .rsp_velocity      (rsp_velocity),
      .rsp_step          (rsp_step),
      .rsp_cutoff        (rsp_cutoff),
      .rsp_last          (rsp_tlast)
   );

   // Pack the result word, zero fill to whole bytes
   assign rsp_tdata = {(RSP_TDATA_W - 33)'(0), rsp_cutoff, rsp_step, rsp_velocity, rsp_note};
   assign rsp_tuser = rsp_kind;

endmodule

`default_nettype wire

// ===== design/mss_ram.sv =====
`default_nettype none

module mss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wen,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     ren,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wen) mem_ff[waddr] <= wdata;
      if (ren) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/mss_mod.sv =====
`default_nettype none

module mss_mod
   import mss_pkg::*;
#(
   parameter int DIVISOR_W = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [COUNT_W-1:0]   dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output logic                      busy,
   output logic      [DIVISOR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(COUNT_W + 1);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;

   // One dividend bit a cycle, restoring form
   assign shifted = {rem_ff, quo_ff[COUNT_W-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(COUNT_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[COUNT_W-2:0], 1'b0};
         rem_in = (shifted >= {1'b0, divisor}) ? diff[DIVISOR_W-1:0]
                                               : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/mss_datapath.sv =====
`default_nettype none

module mss_datapath
   import mss_pkg::*;
#(
   parameter int MAX_STEPS = MSS_MAX_STEPS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  stat,
   // Input word fields
   input  wire logic [ACTION_W-1:0]    in_action,
   input  wire logic                   in_host_running,
   input  wire logic [COUNT_W-1:0]     in_host_step_count,
   input  wire logic [STEP_W-1:0]      in_step_index,
   input  wire entry_type              in_entry,
   // Configuration writes
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // Result word
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output kind_type                    rsp_kind,
   output logic      [NOTE_W-1:0]      rsp_note,
   output logic      [VEL_W-1:0]       rsp_velocity,
   output logic      [STEP_W-1:0]      rsp_step,
   output logic      [CUTOFF_W-1:0]    rsp_cutoff,
   output logic                        rsp_last
);

   localparam int SW    = $clog2(MAX_STEPS);
   localparam int LEN_W = $clog2(MAX_STEPS + 1);

   // Configuration
   logic [PLEN_W-1:0] pattern_length_ff;
   logic [SPS_W-1:0]  samples_per_step_ff;

   // Captured input word
   logic [ACTION_W-1:0] in_action_ff;
   logic                in_host_running_ff;
   logic [COUNT_W-1:0]  in_count_ff;
   logic [STEP_W-1:0]   in_idx_ff;
   entry_type           in_entry_ff;

   // Sequencer state
   logic [SW-1:0]       cur_ff;
   logic [SPS_W-1:0]    pos_ff;
   logic                playing_ff;
   logic                manual_ff;
   logic                host_ff;
   logic                sounding_ff;
   logic [NOTE_W-1:0]   sounding_note_ff;
   logic [MAX_STEPS-1:0] valid_ff;

   // Table read path
   logic [SW-1:0]       rd_addr_ff;
   logic                rd_valid_ff;
   entry_type           cur_entry_ff;
   logic                nxt_active_ff;
   logic [ENTRY_W-1:0]  ram_q;
   entry_type           rd_entry;
   logic [SW-1:0]       rd_addr;
   logic                rd_en;

   // Result register
   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   logic [NOTE_W-1:0]   rsp_note_ff, ev_note_in;
   logic [VEL_W-1:0]    rsp_vel_ff, ev_vel_in;
   logic [STEP_W-1:0]   rsp_step_ff, ev_step_in;
   logic [CUTOFF_W-1:0] rsp_cutoff_ff, ev_cutoff_in;
   logic                rsp_last_ff, ev_last_in;

   logic [LEN_W-1:0]    loop_len;
   logic [LEN_W-1:0]    cur_inc;
   logic                has_next;
   logic [SW-1:0]       nxt_addr;
   logic [SPS_W:0]      pos_inc;
   logic                step_end;
   logic                slide_en;
   logic                off_en;
   logic                on_en;
   logic                idx_ok;
   logic [SW-1:0]       waddr;
   logic                div_busy;
   logic [LEN_W-1:0]    div_rem;
   logic [COUNT_W-1:0]  div_dividend;

   // Clamp the loop length to 1..MAX_STEPS
   always_comb begin
      if (pattern_length_ff == '0) begin
         loop_len = LEN_W'(1);
      end else if ({2'b00, pattern_length_ff} > 7'(MAX_STEPS)) begin
         loop_len = LEN_W'(MAX_STEPS);
      end else begin
         loop_len = LEN_W'(pattern_length_ff);
      end
   end

   assign cur_inc  = LEN_W'(cur_ff) + LEN_W'(1);
   assign has_next = cur_inc < loop_len;
   assign nxt_addr = has_next ? SW'(cur_inc) : cur_ff;
   assign pos_inc  = {1'b0, pos_ff} + (SPS_W+1)'(1);
   assign step_end = pos_inc >= {1'b0, samples_per_step_ff};

   assign off_en   = sounding_ff & ~cur_entry_ff.chained;
   assign on_en    = cur_entry_ff.active;
   assign slide_en = cur_entry_ff.active & cur_entry_ff.slide & has_next & nxt_active_ff;

   assign idx_ok = {3'b000, in_idx_ff} < 7'(MAX_STEPS);
   assign waddr  = SW'(in_idx_ff);

   // Status toward the controller
   assign stat.action       = action_type'(in_action_ff);
   assign stat.tick_go      = playing_ff & ~host_ff;
   assign stat.pos_zero     = pos_ff == '0;
   assign stat.step_end     = step_end;
   assign stat.host_take    = ~manual_ff & in_host_running_ff;
   assign stat.div_busy     = div_busy;
   assign stat.next_differs = div_rem != LEN_W'(cur_ff);
   assign stat.sounding     = sounding_ff;
   assign stat.off_en       = off_en;
   assign stat.slide_en     = slide_en;
   assign stat.on_en        = on_en;
   assign stat.out_free     = ~rsp_valid_ff | rsp_ready;

   // Remainder unit: host position and step advance, both modulo loop length
   assign div_dividend = cmd.div_host ? in_count_ff : COUNT_W'(cur_inc);

   mss_mod #(
      .DIVISOR_W(LEN_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_host | cmd.div_adv),
      .dividend (div_dividend),
      .divisor  (loop_len),
      .busy     (div_busy),
      .remainder(div_rem)
   );

   // Pattern table
   assign rd_en   = cmd.rd_cur | cmd.rd_nxt;
   assign rd_addr = cmd.rd_cur ? cur_ff : nxt_addr;

   mss_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_STEPS)
   ) u_table (
      .clock(clock),
      .wen  (cmd.write & idx_ok),
      .waddr(waddr),
      .wdata(in_entry_ff),
      .ren  (rd_en),
      .raddr(rd_addr),
      .rdata(ram_q)
   );

   // Unwritten entries read as their reset content
   assign rd_entry = rd_valid_ff ? entry_type'(ram_q) : default_entry(IDX_MAX_W'(rd_addr_ff));

   // Capture the input word and the table reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_action_ff       <= in_action;
         in_host_running_ff <= in_host_running;
         in_count_ff        <= in_host_step_count;
         in_idx_ff          <= in_step_index;
         in_entry_ff        <= in_entry;
      end
      if (rd_en) begin
         rd_addr_ff  <= rd_addr;
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.latch_cur) cur_entry_ff  <= rd_entry;
      if (cmd.latch_nxt) nxt_active_ff <= rd_entry.active;
   end

   // Build the next result word
   always_comb begin
      ev_note_in   = '0;
      ev_vel_in    = '0;
      ev_step_in   = cmd.emit_stop ? '0 : STEP_W'(cur_ff);
      ev_cutoff_in = '0;
      ev_last_in   = 1'b0;
      case (cmd.emit_kind)
         KIND_NOTE_OFF: begin
            ev_note_in = sounding_note_ff;
            ev_last_in = cmd.emit_stop | (~slide_en & ~on_en);
         end
         KIND_NOTE_ON: begin
            ev_note_in = cur_entry_ff.note;
            ev_vel_in  = cur_entry_ff.accent ? ACCENT_VELOCITY : cur_entry_ff.velocity;
         end
         KIND_CUTOFF: begin
            ev_cutoff_in = cur_entry_ff.cutoff;
            ev_last_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_kind;
         rsp_note_ff   <= ev_note_in;
         rsp_vel_ff    <= ev_vel_in;
         rsp_step_ff   <= ev_step_in;
         rsp_cutoff_ff <= ev_cutoff_in;
         rsp_last_ff   <= ev_last_in;
      end
   end

   // Control state, configuration and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff   <= PLEN_RESET;
         samples_per_step_ff <= SPS_RESET;
         cur_ff              <= '0;
         pos_ff              <= '0;
         playing_ff          <= 1'b0;
         manual_ff           <= 1'b0;
         host_ff             <= 1'b0;
         sounding_ff         <= 1'b0;
         sounding_note_ff    <= '0;
         valid_ff            <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_PATTERN_LENGTH:   pattern_length_ff   <= csr_wdata[PLEN_W-1:0];
               CSR_SAMPLES_PER_STEP: samples_per_step_ff <= csr_wdata[SPS_W-1:0];
               default: ;
            endcase
         end

         if (cmd.start) begin
            playing_ff <= 1'b1;
            manual_ff  <= 1'b1;
            host_ff    <= 1'b0;
            cur_ff     <= '0;
            pos_ff     <= '0;
         end
         if (cmd.stop) begin
            playing_ff <= 1'b0;
            manual_ff  <= 1'b0;
            host_ff    <= 1'b0;
         end
         if (cmd.host_on) begin
            host_ff    <= 1'b1;
            playing_ff <= 1'b1;
         end
         if (cmd.host_off) host_ff <= 1'b0;
         if (cmd.pos_step) pos_ff <= step_end ? '0 : pos_inc[SPS_W-1:0];
         if (cmd.set_cur) begin
            cur_ff <= SW'(div_rem);
            pos_ff <= '0;
         end
         if (cmd.write && idx_ok) valid_ff[waddr] <= 1'b1;

         // Track the sounding note
         if (cmd.emit && cmd.emit_kind == KIND_NOTE_OFF) sounding_ff <= 1'b0;
         if (cmd.emit && cmd.emit_kind == KIND_NOTE_ON) begin
            sounding_ff      <= 1'b1;
            sounding_note_ff <= cur_entry_ff.note;
         end

         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_note     = rsp_note_ff;
   assign rsp_velocity = rsp_vel_ff;
   assign rsp_step     = rsp_step_ff;
   assign rsp_cutoff   = rsp_cutoff_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/mss_ctrl.sv =====
`default_nettype none

module mss_ctrl
   import mss_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type stat,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ADVANCE,
      S_WAIT_ADV,
      S_WAIT_HOST,
      S_READ_CUR,
      S_LATCH_CUR,
      S_LATCH_NXT,
      S_EV_OFF,
      S_EV_SLIDE,
      S_EV_ON,
      S_EV_CUT,
      S_EV_STOP
   } state_type;

   state_type state_ff, state_in;

   // Sequence the datapath through one input word
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_kind = KIND_NOTE_OFF;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (stat.action)
               ACT_TICK: begin
                  if (stat.tick_go) state_in = stat.pos_zero ? S_READ_CUR : S_ADVANCE;
               end
               ACT_HOST: begin
                  if (stat.host_take) begin
                     cmd.host_on  = 1'b1;
                     cmd.div_host = 1'b1;
                     state_in     = S_WAIT_HOST;
                  end else begin
                     cmd.host_off = 1'b1;
                  end
               end
               ACT_START: cmd.start = 1'b1;
               ACT_STOP: begin
                  cmd.stop = 1'b1;
                  if (stat.sounding) state_in = S_EV_STOP;
               end
               ACT_WRITE: cmd.write = 1'b1;
               default: ;
            endcase
         end
         S_ADVANCE: begin
            cmd.pos_step = 1'b1;
            if (stat.step_end) begin
               cmd.div_adv = 1'b1;
               state_in    = S_WAIT_ADV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WAIT_ADV: begin
            if (!stat.div_busy) begin
               cmd.set_cur = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_WAIT_HOST: begin
            if (!stat.div_busy) begin
               if (stat.next_differs) begin
                  cmd.set_cur = 1'b1;
                  state_in    = S_READ_CUR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ_CUR: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_LATCH_CUR;
         end
         S_LATCH_CUR: begin
            cmd.latch_cur = 1'b1;
            cmd.rd_nxt    = 1'b1;
            state_in      = S_LATCH_NXT;
         end
         S_LATCH_NXT: begin
            cmd.latch_nxt = 1'b1;
            state_in      = S_EV_OFF;
         end
         S_EV_OFF: begin
            cmd.emit_kind = KIND_NOTE_OFF;
            if (!stat.off_en) begin
               state_in = S_EV_SLIDE;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_EV_SLIDE;
            end
         end
         S_EV_SLIDE: begin
            cmd.emit_kind = KIND_SLIDE;
            if (!stat.slide_en) begin
               state_in = S_EV_ON;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_EV_ON;
            end
         end
         S_EV_ON: begin
            cmd.emit_kind = KIND_NOTE_ON;
            if (!stat.on_en) begin
               state_in = S_EV_CUT;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_EV_CUT;
            end
         end
         S_EV_CUT: begin
            cmd.emit_kind = KIND_CUTOFF;
            if (!stat.on_en || stat.out_free) begin
               cmd.emit = stat.on_en;
               state_in = (stat.action == ACT_TICK) ? S_ADVANCE : S_IDLE;
            end
         end
         S_EV_STOP: begin
            cmd.emit_kind = KIND_NOTE_OFF;
            cmd.emit_stop = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== tb/mss_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams and the register port of the step sequencer, predicts
// the event words of every accepted request and compares them in order.
module mss_checker
   import mss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]    req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [KIND_W-1:0]      rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     words_checked
);

   typedef struct {
      kind_type            kind;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
      logic [STEP_W-1:0]   step;
      logic [CUTOFF_W-1:0] cutoff;
      logic                last;
   } midi_event_type;

   // Predicted sequencer state
   entry_type         steps_tbl [MSS_MAX_STEPS];
   logic [PLEN_W-1:0] plen_reg;
   logic [SPS_W-1:0]  sps_reg;
   int unsigned       cur_step;
   int unsigned       position;
   bit                playing;
   bit                manual;
   bit                host_drive;
   bit                sounding;
   logic [NOTE_W-1:0] held_note;

   midi_event_type event_q [$];
   midi_event_type burst_q [$];
   int fails   = 0;
   int checked = 0;
   int queued  = 0;

   assign fail_count    = fails;
   assign pending       = queued;
   assign words_checked = checked;

   function automatic void reset_sequencer();
      for (int i = 0; i < MSS_MAX_STEPS; i++) begin
         steps_tbl[i].note     = BASE_NOTE + NOTE_W'(i % 12);
         steps_tbl[i].velocity = DEF_VELOCITY;
         steps_tbl[i].cutoff   = DEF_CUTOFF;
         steps_tbl[i].active   = 1'b1;
         steps_tbl[i].accent   = 1'b0;
         steps_tbl[i].slide    = 1'b0;
         steps_tbl[i].chained  = 1'b0;
      end
      plen_reg   = PLEN_RESET;
      sps_reg    = SPS_RESET;
      cur_step   = 0;
      position   = 0;
      playing    = 0;
      manual     = 0;
      host_drive = 0;
      sounding   = 0;
      held_note  = '0;
   endfunction

   // Clamp the loop length to 1..MAX_STEPS
   function automatic int unsigned loop_steps();
      if (plen_reg == 0) return 1;
      if (plen_reg > MSS_MAX_STEPS) return MSS_MAX_STEPS;
      return 32'(plen_reg);
   endfunction

   function automatic void add_event(kind_type k, logic [NOTE_W-1:0] note,
                                     logic [VEL_W-1:0] vel, int unsigned step,
                                     logic [CUTOFF_W-1:0] cutoff);
      midi_event_type ev;
      ev.kind     = k;
      ev.note     = note;
      ev.velocity = vel;
      ev.step     = STEP_W'(step);
      ev.cutoff   = cutoff;
      ev.last     = 1'b0;
      burst_q.push_back(ev);
   endfunction

   // Events of entering the current step: note-off, slide, note-on, cutoff
   function automatic void sound_step();
      int unsigned len;
      int unsigned idx;
      entry_type   e;
      len = loop_steps();
      idx = cur_step % MSS_MAX_STEPS;
      e   = steps_tbl[idx];
      if (sounding && !e.chained) begin
         add_event(KIND_NOTE_OFF, held_note, '0, idx, '0);
         sounding = 0;
      end
      if (!e.active) return;
      // slide only toward an active step inside the loop
      if (e.slide && idx + 1 < len && steps_tbl[(idx + 1) % len].active)
         add_event(KIND_SLIDE, '0, '0, idx, '0);
      add_event(KIND_NOTE_ON, e.note, e.accent ? ACCENT_VELOCITY : e.velocity, idx, '0);
      sounding  = 1;
      held_note = e.note;
      add_event(KIND_CUTOFF, '0, '0, idx, e.cutoff);
   endfunction

   function automatic void play_request(logic [ACTION_W-1:0] act,
                                        logic [REQ_TDATA_W-1:0] d);
      int unsigned nxt;
      int unsigned idx;
      case (act)
         ACT_TICK: begin
            if (playing && !host_drive) begin
               if (position == 0) sound_step();
               position++;
               if (position >= sps_reg) begin
                  cur_step = (cur_step + 1) % loop_steps();
                  position = 0;
               end
            end
         end
         ACT_HOST: begin
            if (!manual && d[0]) begin
               nxt        = d[32:1] % loop_steps();
               host_drive = 1;
               playing    = 1;
               if (nxt != cur_step) begin
                  cur_step = nxt;
                  position = 0;
                  sound_step();
               end
            end else begin
               host_drive = 0;
            end
         end
         ACT_START: begin
            playing    = 1;
            manual     = 1;
            host_drive = 0;
            cur_step   = 0;
            position   = 0;
         end
         ACT_STOP: begin
            playing    = 0;
            manual     = 0;
            host_drive = 0;
            if (sounding) begin
               add_event(KIND_NOTE_OFF, held_note, '0, 0, '0);
               sounding = 0;
            end
         end
         ACT_WRITE: begin
            idx = 32'(d[36:33]);
            steps_tbl[idx].note     = d[43:37];
            steps_tbl[idx].velocity = d[50:44];
            steps_tbl[idx].cutoff   = d[65:51];
            steps_tbl[idx].active   = d[66];
            steps_tbl[idx].accent   = d[67];
            steps_tbl[idx].slide    = d[68];
            steps_tbl[idx].chained  = d[69];
         end
         default: ;
      endcase
      // mark the final event of this request and queue the burst
      if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
      foreach (burst_q[i]) event_q.push_back(burst_q[i]);
      burst_q.delete();
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   initial reset_sequencer();

   always @(posedge clock) begin
      midi_event_type want;
      if (reset) begin
         reset_sequencer();
         event_q.delete();
      end else begin
         // compare a delivered word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (event_q.size() == 0) begin
               $error("unexpected event word: kind %0d note %0d step %0d",
                      rsp_tuser, rsp_tdata[6:0], rsp_tdata[17:14]);
               fails++;
            end else begin
               want = event_q.pop_front();
               check_field("event_kind", want.kind, rsp_tuser);
               check_field("event_note", want.note, rsp_tdata[6:0]);
               check_field("event_velocity", want.velocity, rsp_tdata[13:7]);
               check_field("event_step", want.step, rsp_tdata[17:14]);
               check_field("event_cutoff", want.cutoff, rsp_tdata[32:18]);
               check_field("last_event", want.last, rsp_tlast);
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_PATTERN_LENGTH:   plen_reg = csr_wdata[PLEN_W-1:0];
               CSR_SAMPLES_PER_STEP: sps_reg  = csr_wdata[SPS_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) play_request(req_tuser, req_tdata);
      end
      queued = event_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mss_pkg::*;

   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 100;
   localparam int BLOCK_WORDS   = 15;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [ACTION_W-1:0]    req_tuser  = ACT_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_PATTERN_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int          fail_count;
   int          pending;
   int          words_checked;
   int          send_idle_pct = 7;
   int          recv_idle_pct = 73;
   int          words_sent    = 0;
   int          settings      = 0;
   int          idle_cycles   = 0;
   int unsigned host_pos      = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   midi_step_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mss_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .words_checked (words_checked)
   );

   // Stall the result stream at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] noise_data();
      logic [REQ_TDATA_W-1:0] d;
      d = REQ_TDATA_W'({$urandom, $urandom, $urandom});
      d[REQ_TDATA_W-1:70] = '0;
      return d;
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] step_data(
      logic [STEP_W-1:0] idx, logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel,
      logic [CUTOFF_W-1:0] cutoff, logic active, logic accent, logic slide,
      logic chained);
      logic [REQ_TDATA_W-1:0] d;
      d        = '0;
      d[0]     = 1'($urandom_range(1));
      d[32:1]  = $urandom;
      d[36:33] = idx;
      d[43:37] = note;
      d[50:44] = vel;
      d[65:51] = cutoff;
      d[66]    = active;
      d[67]    = accent;
      d[68]    = slide;
      d[69]    = chained;
      return d;
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] host_data(logic running,
                                                         logic [COUNT_W-1:0] count);
      logic [REQ_TDATA_W-1:0] d;
      d       = noise_data();
      d[0]    = running;
      d[32:1] = count;
      return d;
   endfunction

   // Present one request word and hold it until accepted
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [REQ_TDATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_plain(input logic [ACTION_W-1:0] act);
      send_word(act, noise_data());
   endtask

   task automatic send_host(input logic running, input logic [COUNT_W-1:0] count);
      send_word(ACT_HOST, host_data(running, count));
   endtask

   task automatic send_random_step();
      send_word(ACT_WRITE, step_data(STEP_W'($urandom_range(15)),
                                     NOTE_W'($urandom_range(127)),
                                     VEL_W'($urandom_range(127)),
                                     CUTOFF_W'($urandom_range(20000)),
                                     $urandom_range(9) != 0, 1'($urandom_range(1)),
                                     1'($urandom_range(1)), $urandom_range(2) == 0));
   endtask

   // Wait for the last event, let the block settle, then write both registers
   task automatic set_config(input logic [CSR_DATA_W-1:0] plen,
                             input logic [CSR_DATA_W-1:0] sps);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_PATTERN_LENGTH;
      csr_wdata <= plen;
      @(negedge clock);
      csr_index <= CSR_SAMPLES_PER_STEP;
      csr_wdata <= sps;
      @(negedge clock);
      csr_wen <= 1'b0;
      settings++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_length();
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(7))
         0:       v = 0;
         1:       v = 1;
         2:       v = 16;
         3:       v = CSR_DATA_W'($urandom_range(17, 31));
         default: v = CSR_DATA_W'($urandom_range(2, 8));
      endcase
      // upper bits beyond the register are dropped
      if ($urandom_range(3) == 0) v = v | (CSR_DATA_W'($urandom) & 16'hFFE0);
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_sps();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 1;
         2:       return 16'hFFFF;
         3:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(2, 5));
      endcase
   endfunction

   // One random word: mostly well-formed play, some noise
   task automatic send_random(input bit host_style);
      int r;
      r = $urandom_range(99);
      if (host_style) begin
         if (r < 50) begin
            host_pos = ($urandom_range(9) == 0) ? $urandom : host_pos + $urandom_range(1);
            send_host($urandom_range(9) != 0, host_pos);
         end else if (r < 65) send_plain(ACT_TICK);
         else if (r < 83) send_random_step();
         else if (r < 90) send_plain(ACT_STOP);
         else if (r < 95) send_plain(ACT_START);
         else send_plain(ACTION_W'($urandom_range(5, 7)));
      end else begin
         if (r < 62) send_plain(ACT_TICK);
         else if (r < 80) send_random_step();
         else if (r < 86) send_plain(ACT_STOP);
         else if (r < 92) send_plain(ACT_START);
         else if (r < 96) send_host(1'($urandom_range(1)), $urandom);
         else send_plain(ACTION_W'($urandom_range(5, 7)));
      end
   endtask

   initial begin
      bit host_style;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, ties, slides, rests, stop, host transport
      send_word(ACT_WRITE, step_data(0, 127, 0, 20000, 1, 1, 1, 0));
      send_word(ACT_WRITE, step_data(1, 0, 127, 0, 1, 0, 1, 1));
      send_word(ACT_WRITE, step_data(2, 64, 100, 500, 0, 0, 0, 0));
      send_word(ACT_WRITE, step_data(3, 90, 1, 16384, 1, 0, 0, 1));
      send_word(ACT_WRITE, step_data(15, 127, 127, 20000, 1, 1, 1, 1));
      set_config(4, 1);
      send_plain(ACT_START);
      repeat (5) send_plain(ACT_TICK);
      send_plain(ACT_STOP);
      send_plain(ACT_STOP);
      send_plain(3'd5);
      send_plain(3'd6);
      send_plain(3'd7);
      send_host(1'b0, 32'h0000_0002);
      send_host(1'b1, 32'hFFFF_FFFF);
      send_host(1'b1, 32'hFFFF_FFFF);
      send_plain(ACT_TICK);
      send_host(1'b1, 32'd6);
      send_host(1'b0, 32'd7);
      send_plain(ACT_TICK);
      send_plain(ACT_START);
      send_host(1'b1, 32'd1);
      send_plain(ACT_TICK);

      // Random: three idle profiles, register settings changed between blocks
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 7;  recv_idle_pct = 73; end
            1: begin send_idle_pct = 73; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            set_config(pick_length(), pick_sps());
            host_style = ($urandom_range(2) == 0);
            if (host_style) send_plain(ACT_STOP);
            else if ($urandom_range(1)) send_plain(ACT_START);
            for (int k = 0; k < BLOCK_WORDS; k++) send_random(host_style);
         end
      end

      // Drain and settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d request words over %0d register settings and three stall profiles;",
               words_sent, settings);
      $display("compared %0d event words against the predicted note, slide and cutoff events.",
               words_checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/mss_pkg.sv
design/mss_ram.sv
design/mss_mod.sv
design/mss_datapath.sv
design/mss_ctrl.sv
design/midi_step_sequencer.sv
tb/mss_checker.sv
tb/testbench.sv
